// ===== rtl/core/rwc_pkg.sv =====
`default_nettype none
package rwc_pkg;

   localparam int KERNEL_SIZE = 3;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COEF_BITS   = 12;

   localparam int HALF_SPAN = KERNEL_SIZE / 2;
   localparam int SPAN      = 2 * HALF_SPAN + 1;
   localparam int FRAC_BITS = 8;

   localparam int CFG_DIM_W  = 11;
   localparam int KROW_W     = 60;
   localparam int KERNEL_REGS = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + SPAN + 1);
   localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF_SPAN * (MAX_WIDTH + 1) + 1);

   localparam int PROD_W = 8 + 1 + COEF_BITS;
   localparam int SUM_W  = PROD_W + $clog2(SPAN * SPAN);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_KERNEL_ROW_0 = 3'd2,
      REG_KERNEL_ROW_1 = 3'd3,
      REG_KERNEL_ROW_2 = 3'd4,
      REG_KERNEL_ROW_3 = 3'd5,
      REG_KERNEL_ROW_4 = 3'd6
   } reg_index_type;

   typedef logic [COL_W-1:0]     col_type;
   typedef logic [COEF_BITS-1:0] coef_type;
   typedef coef_type [SPAN-1:0]  coef_row_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] red;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] blue;
   } rgb_sum_type;

   typedef struct packed {
      logic    adv;
      logic    push;
      col_type rd_col;
      col_type wr_col;
   } cell_ctl_type;

   typedef struct packed {
      logic [SPAN-1:0] col_ok;
      logic            row_ok;
   } cell_mask_type;

   function automatic logic signed [PROD_W-1:0] mul_px(logic [7:0] p, coef_type c);
      logic signed [PROD_W-1:0] r;
      r = PROD_W'($signed({1'b0, p}) * $signed(c));
      return r;
   endfunction

   function automatic logic [7:0] clamp_byte(logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] q;
      q = s >>> FRAC_BITS;
      if (s <= 0) begin
         return 8'd0;
      end
      if (q > 255) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rwc_if.sv =====
`default_nettype none
interface rwc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source(output valid, mode, in_red, in_green, in_blue, input ready);
   modport sink(input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface rwc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_end;

   modport source(output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink(input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rwc_cell.sv =====
`default_nettype none
module rwc_cell (
   input  wire logic                  clock,
   input  wire rwc_pkg::cell_ctl_type ctl,
   input  wire rwc_pkg::cell_mask_type mask,
   input  wire rwc_pkg::coef_row_type coef,
   input  wire rwc_pkg::pixel_type    v_in,
   output rwc_pkg::pixel_type         v_out,
   output rwc_pkg::rgb_sum_type       row_sum
);
   import rwc_pkg::*;

   pixel_type mem [MAX_WIDTH];
   pixel_type rd_ff;
   pixel_type win_ff [SPAN];
   logic signed [PROD_W-1:0] pr_ff [SPAN];
   logic signed [PROD_W-1:0] pg_ff [SPAN];
   logic signed [PROD_W-1:0] pb_ff [SPAN];
   rgb_sum_type sum_in;
   rgb_sum_type sum_ff;

   // line store: previous row at this column, written as the column moves on
   always_ff @(posedge clock) begin
      if (ctl.adv && ctl.push) begin
         mem[ctl.wr_col] <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         if (ctl.push && ctl.wr_col == ctl.rd_col) begin
            rd_ff <= v_in;
         end else begin
            rd_ff <= mem[ctl.rd_col];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv && ctl.push) begin
         win_ff[0] <= v_in;
         for (int j = 1; j < SPAN; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         for (int j = 0; j < SPAN; j++) begin
            if (mask.row_ok && mask.col_ok[j]) begin
               pr_ff[j] <= mul_px(win_ff[j].red, coef[j]);
               pg_ff[j] <= mul_px(win_ff[j].green, coef[j]);
               pb_ff[j] <= mul_px(win_ff[j].blue, coef[j]);
            end else begin
               pr_ff[j] <= '0;
               pg_ff[j] <= '0;
               pb_ff[j] <= '0;
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < SPAN; j++) begin
         sum_in.red   = sum_in.red + SUM_W'(pr_ff[j]);
         sum_in.green = sum_in.green + SUM_W'(pg_ff[j]);
         sum_in.blue  = sum_in.blue + SUM_W'(pb_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         sum_ff <= sum_in;
      end
   end

   assign v_out   = rd_ff;
   assign row_sum = sum_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_window_convolution.sv =====
`default_nettype none
// channel  dir  handshake      payload
// req_ch   in   valid/ready    mode, in_red, in_green, in_blue
// rsp_ch   out  valid/ready    out_red, out_green, out_blue, frame_end
// csr      in   csr_wr_en      csr_index, csr_wdata
//
// One item per cycle while the result is not stalled.
// A result passes line store read, window, multiply, row add and final add.
// Synchronous reset clears counters, pipeline flags and kernel rows and sets width and height to one;
// line stores need no clear. A stalled result holds the whole pipe: req_ch.ready = !rsp_ch.valid || rsp_ch.ready.
module rgb_window_convolution (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rwc_req_if.sink                                 req_ch,
   rwc_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_wr_en,
   input  wire logic [rwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rwc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rwc_pkg::*;

   localparam int XW = WDIM_W + 2;
   localparam int YW = ROW_W + 2;

   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic [KROW_W-1:0]    kern_ff [KERNEL_REGS];

   logic [CNT_W-1:0] n_ff, n_in;
   col_type          rx_ff, rx_in, ox_ff, ox_in;
   logic [ROW_W-1:0] ry_ff, ry_in, oy_ff, oy_in;

   logic [WDIM_W-1:0] w_eff;
   logic [HDIM_W-1:0] h_eff;
   logic [CNT_W-1:0]  delay;
   logic adv, accept, in_frame, ignore, act, started, abandon, emit, last, clear;
   logic [SPAN-1:0] col_ok_a, row_ok_b;

   logic            b_push_ff, b_res_ff, b_last_ff;
   col_type         b_col_ff;
   pixel_type       b_pix_ff;
   logic [SPAN-1:0] b_colok_ff, b_rowok_ff, c_colok_ff, c_rowok_ff;
   logic            c_res_ff, c_last_ff, d_res_ff, d_last_ff, e_res_ff, e_last_ff;

   logic       out_valid_ff;
   pixel_type  out_ff;
   logic       out_last_ff;

   cell_ctl_type ctl;
   pixel_type    v_in [SPAN];
   pixel_type    v_out [SPAN];
   rgb_sum_type  row_sum [SPAN];
   rgb_sum_type  total;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(1);
         height_ff <= CFG_DIM_W'(1);
         for (int i = 0; i < KERNEL_REGS; i++) begin
            kern_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:  width_ff   <= csr_wdata[CFG_DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff  <= csr_wdata[CFG_DIM_W-1:0];
            REG_KERNEL_ROW_0: kern_ff[0] <= csr_wdata[KROW_W-1:0];
            REG_KERNEL_ROW_1: kern_ff[1] <= csr_wdata[KROW_W-1:0];
            REG_KERNEL_ROW_2: kern_ff[2] <= csr_wdata[KROW_W-1:0];
            REG_KERNEL_ROW_3: kern_ff[3] <= csr_wdata[KROW_W-1:0];
            REG_KERNEL_ROW_4: kern_ff[4] <= csr_wdata[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WDIM_W'(1);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = WDIM_W'(MAX_WIDTH);
      end else begin
         w_eff = WDIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HDIM_W'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = HDIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = HDIM_W'(height_ff);
      end
   end

   assign delay    = CNT_W'(w_eff) * CNT_W'(HALF_SPAN) + CNT_W'(HALF_SPAN);
   assign adv      = !out_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && adv;
   assign in_frame = YW'(ry_ff) < YW'(h_eff);
   assign ignore   = req_ch.mode && in_frame;
   assign act      = accept && !ignore;
   assign started  = n_ff >= delay;
   assign abandon  = started && (YW'(oy_ff) >= YW'(h_eff));
   assign emit     = started && !abandon;
   assign last     = emit && (XW'(ox_ff) + XW'(1) == XW'(w_eff))
                          && (YW'(oy_ff) + YW'(1) == YW'(h_eff));
   assign clear    = abandon || last;

   always_comb begin
      for (int a = 0; a < SPAN; a++) begin
         col_ok_a[a] = (XW'(ox_ff) + XW'(a) >= XW'(HALF_SPAN))
                    && (XW'(ox_ff) + XW'(a) < XW'(w_eff) + XW'(HALF_SPAN));
         row_ok_b[a] = (YW'(oy_ff) + YW'(a) >= YW'(HALF_SPAN))
                    && (YW'(oy_ff) + YW'(a) < YW'(h_eff) + YW'(HALF_SPAN));
      end
   end

   always_comb begin
      n_in  = n_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      if (act) begin
         if (clear) begin
            n_in  = '0;
            rx_in = '0;
            ry_in = '0;
            ox_in = '0;
            oy_in = '0;
         end else begin
            n_in = n_ff + CNT_W'(1);
            if (XW'(rx_ff) + XW'(1) >= XW'(w_eff)) begin
               rx_in = '0;
               ry_in = ry_ff + ROW_W'(1);
            end else begin
               rx_in = rx_ff + COL_W'(1);
            end
            if (emit) begin
               if (XW'(ox_ff) + XW'(1) >= XW'(w_eff)) begin
                  ox_in = '0;
                  oy_in = oy_ff + ROW_W'(1);
               end else begin
                  ox_in = ox_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff  <= '0;
         rx_ff <= '0;
         ry_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
      end else begin
         n_ff  <= n_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         ox_ff <= ox_in;
         oy_ff <= oy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_push_ff    <= 1'b0;
         b_res_ff     <= 1'b0;
         c_res_ff     <= 1'b0;
         d_res_ff     <= 1'b0;
         e_res_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b_push_ff    <= act;
         b_res_ff     <= act && emit;
         c_res_ff     <= b_res_ff;
         d_res_ff     <= c_res_ff;
         e_res_ff     <= d_res_ff;
         out_valid_ff <= e_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_last_ff  <= last;
         b_col_ff   <= rx_ff;
         b_pix_ff   <= '{red: req_ch.in_red, green: req_ch.in_green, blue: req_ch.in_blue};
         b_colok_ff <= col_ok_a;
         b_rowok_ff <= row_ok_b;
         c_last_ff  <= b_last_ff;
         c_colok_ff <= b_colok_ff;
         c_rowok_ff <= b_rowok_ff;
         d_last_ff  <= c_last_ff;
         e_last_ff  <= d_last_ff;
         out_last_ff <= e_last_ff;
         out_ff.red   <= clamp_byte(total.red);
         out_ff.green <= clamp_byte(total.green);
         out_ff.blue  <= clamp_byte(total.blue);
      end
   end

   assign ctl.adv    = adv;
   assign ctl.push   = b_push_ff;
   assign ctl.rd_col = rx_ff;
   assign ctl.wr_col = b_col_ff;

   // cell k holds vertical offset SPAN-1-k, window tap j horizontal offset SPAN-1-j
   for (genvar k = 0; k < SPAN; k++) begin : g_cell
      cell_mask_type mask;
      coef_row_type  coef;

      for (genvar j = 0; j < SPAN; j++) begin : g_tap
         assign mask.col_ok[j] = c_colok_ff[SPAN-1-j];
         assign coef[j] = kern_ff[SPAN-1-j][(SPAN-1-k)*COEF_BITS +: COEF_BITS];
      end
      assign mask.row_ok = c_rowok_ff[SPAN-1-k];

      if (k == 0) begin : g_head
         assign v_in[k] = b_pix_ff;
      end else begin : g_link
         assign v_in[k] = v_out[k-1];
      end

      rwc_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .mask    (mask),
         .coef    (coef),
         .v_in    (v_in[k]),
         .v_out   (v_out[k]),
         .row_sum (row_sum[k])
      );
   end

   always_comb begin
      total = '0;
      for (int k = 0; k < SPAN; k++) begin
         total.red   = total.red + row_sum[k].red;
         total.green = total.green + row_sum[k].green;
         total.blue  = total.blue + row_sum[k].blue;
      end
   end

   assign req_ch.ready     = adv;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_red   = out_ff.red;
   assign rsp_ch.out_green = out_ff.green;
   assign rsp_ch.out_blue  = out_ff.blue;
   assign rsp_ch.frame_end = out_last_ff;

`ifndef SYNTH
   a_origin: assert property (@(posedge clock) disable iff (reset)
      (n_ff == '0) |-> (rx_ff == '0 && ry_ff == '0))
      else $error("input position not at origin with empty count");

   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      !started |-> (ox_ff == '0 && oy_ff == '0))
      else $error("output position moved before window filled");

   a_ignore: assert property (@(posedge clock) disable iff (reset)
      (accept && ignore) |=> $stable(n_ff))
      else $error("ignored drain item changed the count");

   a_last: assert property (@(posedge clock) disable iff (reset)
      (act && last) |=> (n_ff == '0 && oy_ff == '0))
      else $error("frame end did not clear the counters");
`endif

endmodule
`default_nettype wire
